>>> hw/rtl/tpv_pkg.sv
// Shared types and constants for the tonality path Viterbi unit.
`timescale 1ns / 1ps
package tpv_pkg;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_RANK   = 2'd1;
  localparam logic [1:0] FUNC_EMPTY  = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [2:0] CFG_TON_COUNT     = 3'd0;
  localparam logic [2:0] CFG_TONAL_MODE    = 3'd1;
  localparam logic [2:0] CFG_GLOBAL_TON    = 3'd2;
  localparam logic [2:0] CFG_SPELL_WEIGHT  = 3'd3;
  localparam logic [2:0] CFG_MOVE_WEIGHT   = 3'd4;
  localparam logic [2:0] CFG_GLOBAL_WEIGHT = 3'd5;

  localparam int CNT_W = 6;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] ton;
    logic [4:0] from_ton;
    logic [4:0] value;
  } in_t;

  typedef struct packed {
    logic [5:0] measure;
    logic [4:0] best_ton;
    logic       last;
    logic       failed;
  } out_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RANK   = 2'd1,
    CMD_EMPTY  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] ton;
    logic [4:0] from_ton;
    logic [4:0] value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] tons;
    logic             tonal_mode;
    logic [4:0]       global_ton;
    logic [2:0]       spell_weight;
    logic [2:0]       move_weight;
    logic [2:0]       global_weight;
  } cfg_t;

endpackage

>>> hw/rtl/tpv_front.sv
// Front end: accepts input transactions, drops ignored ones, queues the rest.
`timescale 1ns / 1ps
module tpv_front import tpv_pkg::*; #(
  parameter int MAX_TONS = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  input  cfg_t  cfg,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       keep;
  logic       push;
  logic       pop;
  item_t      cls;

  always_comb begin
    cls.ton      = in_data.ton;
    cls.from_ton = in_data.from_ton;
    cls.value    = in_data.value;
    cls.cmd      = CMD_LOAD;
    keep         = 1'b1;
    case (in_data.func)
      FUNC_LOAD: begin
        cls.cmd = CMD_LOAD;
        keep    = (in_data.ton < MAX_TONS) && (in_data.from_ton < MAX_TONS);
      end
      FUNC_RANK: begin
        cls.cmd = CMD_RANK;
        keep    = {1'b0, in_data.ton} < cfg.tons;
      end
      FUNC_EMPTY: begin
        cls.cmd = CMD_EMPTY;
      end
      default: begin
        cls.cmd = CMD_FINISH;
      end
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = q[rp];
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= cls;
        wp    <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/tpv_engine.sv
// Back end: trellis cost update, final pick and backtrace with result register.
`timescale 1ns / 1ps
module tpv_engine import tpv_pkg::*; #(
  parameter int MAX_TONS     = 32,
  parameter int MAX_MEASURES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  localparam int TW  = $clog2(MAX_TONS);
  localparam int MIW = (MAX_MEASURES > 1) ? $clog2(MAX_MEASURES) : 1;
  localparam int MCW = $clog2(MAX_MEASURES + 1);
  localparam int SW  = COST_BITS + 2;
  localparam logic [COST_BITS-1:0] INF = {COST_BITS{1'b1}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GREAD = 9'b000000010,
    S_GCAP  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_ESCAN = 9'b000010000,
    S_CLOSE = 9'b000100000,
    S_FMIN  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_BPW   = 9'b100000000
  } state_t;

  state_t               state;
  item_t                item;
  logic [MCW-1:0]       mc;
  logic [MCW-1:0]       em;
  logic                 started;
  logic                 overflow;
  logic                 fail;
  logic [MAX_MEASURES-1:0] has_pred;
  logic [COST_BITS-1:0] prev [MAX_TONS];
  logic [COST_BITS-1:0] cur  [MAX_TONS];
  logic [4:0]           dist_mem [1 << (2 * TW)];
  logic [TW-1:0]        bp_mem   [1 << (MIW + TW)];
  logic [4:0]           dist_q;
  logic [TW-1:0]        bp_q;
  logic [2*TW-1:0]      dist_raddr;
  logic                 bp_we;
  logic [MIW+TW-1:0]    bp_waddr;
  logic [TW-1:0]        bp_wdata;
  logic [CNT_W-1:0]     scan_i;
  logic                 v1;
  logic [TW-1:0]        i1;
  logic [SW-1:0]        base;
  logic [COST_BITS-1:0] best;
  logic [COST_BITS-1:0] bestpc;
  logic [TW-1:0]        bestp;
  logic                 found;
  logic [TW-1:0]        bi;
  logic [TW-1:0]        t_ix;
  logic [TW-1:0]        g_ix;
  logic [TW-1:0]        s_ix;
  logic [MIW-1:0]       m_ix;
  logic                 gvalid;
  logic [4:0]           gd;
  logic [4:0]           egd;
  logic [COST_BITS-1:0] pc;
  logic [COST_BITS-1:0] c;
  logic [COST_BITS-1:0] first_cost;
  logic [COST_BITS-1:0] ecost;
  logic                 closing;
  logic                 scan_more;
  logic                 out_free;

  function automatic logic [COST_BITS-1:0] sat(input logic [SW-1:0] x);
    if (x >= {{(SW-COST_BITS){1'b0}}, INF}) begin
      return INF;
    end
    return x[COST_BITS-1:0];
  endfunction

  assign t_ix      = TW'(item.ton);
  assign g_ix      = TW'(cfg.global_ton);
  assign s_ix      = TW'(scan_i);
  assign m_ix      = MIW'(mc);
  assign gvalid    = cfg.global_ton < MAX_TONS;
  assign gd        = gvalid ? dist_q : 5'd0;
  assign egd       = (cfg.tonal_mode && gvalid) ? dist_q : 5'd0;
  assign closing   = ({1'b0, item.ton} == cfg.tons - 1'b1);
  assign scan_more = scan_i < cfg.tons;
  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == S_IDLE);
  assign pc        = prev[i1];

  assign c = sat(SW'(pc) + SW'(cfg.move_weight) * SW'(dist_q) + base);
  assign first_cost = cfg.tonal_mode
      ? sat(SW'({1'b0, cfg.move_weight} + {1'b0, cfg.global_weight}) * SW'(gd)
            + SW'(cfg.spell_weight) * SW'(item.value))
      : COST_BITS'(item.value);
  assign ecost = !started ? ((32'(i1) == 32'(cfg.global_ton)) ? '0 : INF)
                          : sat(SW'(prev[i1]) + SW'(egd));

  always_comb begin
    case (state)
      S_GREAD: dist_raddr = {g_ix, t_ix};
      S_SCAN:  dist_raddr = {s_ix, t_ix};
      S_ESCAN: dist_raddr = {g_ix, s_ix};
      default: dist_raddr = '0;
    endcase
  end

  always_comb begin
    bp_we    = 1'b0;
    bp_waddr = {m_ix, t_ix};
    bp_wdata = t_ix;
    case (state)
      S_GCAP: begin
        bp_we = !started;
      end
      S_SCAN: begin
        bp_we    = !v1 && !scan_more;
        bp_wdata = found ? bestp : t_ix;
      end
      S_ESCAN: begin
        bp_we    = v1;
        bp_waddr = {m_ix, i1};
        bp_wdata = i1;
      end
      default: begin
        bp_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_item.cmd == CMD_LOAD) begin
      dist_mem[{TW'(q_item.from_ton), TW'(q_item.ton)}] <= q_item.value;
    end
    dist_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= bp_wdata;
    end
    bp_q <= bp_mem[{MIW'(em), bi}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mc        <= '0;
      started   <= 1'b0;
      overflow  <= 1'b0;
      has_pred  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            case (q_item.cmd)
              CMD_RANK: begin
                if (mc >= MCW'(MAX_MEASURES)) begin
                  overflow <= 1'b1;
                end else begin
                  state <= S_GREAD;
                end
              end
              CMD_EMPTY: begin
                if (mc >= MCW'(MAX_MEASURES)) begin
                  overflow <= 1'b1;
                end else if (!started && !cfg.tonal_mode) begin
                  has_pred[m_ix] <= 1'b0;
                  mc             <= mc + 1'b1;
                end else begin
                  scan_i <= '0;
                  v1     <= 1'b0;
                  state  <= S_ESCAN;
                end
              end
              CMD_FINISH: begin
                if (started && !overflow && mc != '0) begin
                  scan_i <= '0;
                  fail   <= 1'b0;
                  state  <= S_FMIN;
                end else begin
                  fail  <= 1'b1;
                  em    <= '0;
                  bi    <= '0;
                  state <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_GREAD: begin
          state <= S_GCAP;
        end
        S_GCAP: begin
          base <= SW'(cfg.spell_weight) * SW'(item.value)
                + (cfg.tonal_mode ? SW'(cfg.global_weight) * SW'(gd) : '0);
          if (!started) begin
            cur[t_ix] <= first_cost;
            state     <= closing ? S_CLOSE : S_IDLE;
          end else begin
            scan_i <= '0;
            v1     <= 1'b0;
            found  <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          v1 <= scan_more;
          i1 <= s_ix;
          if (scan_more) begin
            scan_i <= scan_i + 1'b1;
          end
          if (v1 && pc != INF) begin
            if (!found || c < best || (c == best && pc < bestpc)) begin
              found  <= 1'b1;
              best   <= c;
              bestpc <= pc;
              bestp  <= i1;
            end
          end
          if (!v1 && !scan_more) begin
            cur[t_ix] <= found ? best : INF;
            state     <= closing ? S_CLOSE : S_IDLE;
          end
        end
        S_ESCAN: begin
          v1 <= scan_more;
          i1 <= s_ix;
          if (scan_more) begin
            scan_i <= scan_i + 1'b1;
          end
          if (v1) begin
            cur[i1] <= ecost;
          end
          if (!v1 && !scan_more) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          for (int i = 0; i < MAX_TONS; i++) begin
            if (i < 32'(cfg.tons)) begin
              prev[i] <= cur[i];
            end
          end
          has_pred[m_ix] <= started;
          started        <= 1'b1;
          mc             <= mc + 1'b1;
          state          <= S_IDLE;
        end
        S_FMIN: begin
          if (scan_more) begin
            if (scan_i == '0 || prev[s_ix] < best) begin
              best <= prev[s_ix];
              bi   <= s_ix;
            end
            scan_i <= scan_i + 1'b1;
          end else begin
            if (best == INF) begin
              fail <= 1'b1;
              em   <= '0;
              bi   <= '0;
            end else begin
              em <= mc - 1'b1;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data.measure  <= 6'(em);
            out_data.best_ton <= 5'(bi);
            out_data.last     <= fail || (em == '0);
            out_data.failed   <= fail;
            if (fail || em == '0) begin
              mc       <= '0;
              started  <= 1'b0;
              overflow <= 1'b0;
              has_pred <= '0;
              state    <= S_IDLE;
            end else if (has_pred[MIW'(em)]) begin
              state <= S_BPW;
            end else begin
              em <= em - 1'b1;
            end
          end
        end
        S_BPW: begin
          bi    <= bp_q;
          em    <= em - 1'b1;
          state <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/tonality_path_viterbi_unit.sv
// Top level of the tonality path Viterbi unit: configuration registers, front and back ends.
//
// A rank transaction reads the distance from the global ton, then, once a measure has been
// closed, scans every predecessor ton once, one compare-add per cycle through the distance
// memory's registered read port; a close step follows when it closes the measure. A finish
// does the final pick, then the backtrace of the reported measures. A two-entry queue sits
// between input and back end; the result register lets a finished result wait while work
// continues. Configuration writes are always ready.
`timescale 1ns / 1ps
module tonality_path_viterbi_unit import tpv_pkg::*; #(
  parameter int MAX_TONS     = 32,
  parameter int MAX_MEASURES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_data
);

  localparam int LIM = (MAX_TONS < 32) ? MAX_TONS : 32;

  logic [5:0] ton_count;
  logic       tonal_mode;
  logic [4:0] global_ton;
  logic [2:0] spell_weight;
  logic [2:0] move_weight;
  logic [2:0] global_weight;
  cfg_t       cfg;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ton_count     <= 6'd32;
      tonal_mode    <= 1'b0;
      global_ton    <= 5'd0;
      spell_weight  <= 3'd2;
      move_weight   <= 3'd1;
      global_weight <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TON_COUNT:     ton_count     <= cfg_data;
        CFG_TONAL_MODE:    tonal_mode    <= cfg_data[0];
        CFG_GLOBAL_TON:    global_ton    <= cfg_data[4:0];
        CFG_SPELL_WEIGHT:  spell_weight  <= cfg_data[2:0];
        CFG_MOVE_WEIGHT:   move_weight   <= cfg_data[2:0];
        CFG_GLOBAL_WEIGHT: global_weight <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (ton_count == '0) begin
      cfg.tons = 6'd1;
    end else if (ton_count > 6'(LIM)) begin
      cfg.tons = 6'(LIM);
    end else begin
      cfg.tons = ton_count;
    end
    cfg.tonal_mode    = tonal_mode;
    cfg.global_ton    = global_ton;
    cfg.spell_weight  = spell_weight;
    cfg.move_weight   = move_weight;
    cfg.global_weight = global_weight;
  end

  tpv_front #(
    .MAX_TONS (MAX_TONS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tpv_engine #(
    .MAX_TONS     (MAX_TONS),
    .MAX_MEASURES (MAX_MEASURES),
    .COST_BITS    (COST_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
